// File: rtl/dobf_pkg.sv
package dobf_pkg;

  // Field widths fixed by the stream format
  localparam int CMD_W       = 2;
  localparam int PUSH_W      = 32;
  localparam int POP_W       = 32;
  localparam int DROP_W      = 16;
  localparam int LEVEL_W     = 6;
  localparam int OUT_TDATA_W = 1 + POP_W + DROP_W + 1 + LEVEL_W;

  // Defaults for the top-level parameters
  localparam int DEFAULT_DEPTH      = 32;
  localparam int DEFAULT_WORD_WIDTH = 32;

  // Limit register reset and drop counter ceiling
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 6'd30;
  localparam logic [DROP_W-1:0]  DROP_MAX        = 16'hFFFF;

  // Command codes carried on in_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 2'd0,
    CMD_POP      = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_CLR_DROP = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // input beat taken: latch it and read the head entry
    logic commit;   // apply the command and load the result register
  } ctrl_cmd_t;

endpackage

// File: rtl/drop_oldest_bounded_fifo.sv
// Drop-oldest FIFO with a configurable occupancy limit.
// Flow: the accepted beat and the head entry are registered, then the command is applied
// in execution and its result registered; no new command is taken until execution ends.
// A stalled result blocks acceptance of the next command; the current one waits in execution.
// Reset (synchronous, rst_n low): pointers, level and drop count go to zero, limit to 30.
// The word store is not cleared; entries are defined once written.
module drop_oldest_bounded_fifo #(
  parameter int DEPTH      = dobf_pkg::DEFAULT_DEPTH,
  parameter int WORD_WIDTH = dobf_pkg::DEFAULT_WORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dobf_pkg::PUSH_W-1:0]      in_tdata,  // push_word
  input  logic [dobf_pkg::CMD_W-1:0]       in_tuser,  // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // success, pop_word, drop_count, full_flag, fill_level
  output logic [dobf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [dobf_pkg::LEVEL_W-1:0]     cfg_wr_data  // max_level
);
  import dobf_pkg::*;

  ctrl_cmd_t cmd;

  dobf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dobf_dpath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_command   (in_tuser),
    .in_push_word (in_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_tdata    (out_tdata)
  );

endmodule

// File: rtl/dobf_ctrl.sv
module dobf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output dobf_pkg::ctrl_cmd_t cmd
);
  import dobf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result slot can take a new result this cycle
  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_EXEC: begin
        cmd.commit = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Hold the result valid until the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cap_commit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

  a_exec_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_valid_r && !out_tready) |=> (state_r == ST_EXEC))
    else $error("command left execution while the result slot was busy");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed result not presented");
`endif

endmodule

// File: rtl/dobf_dpath.sv
module dobf_dpath #(
  parameter int DEPTH      = dobf_pkg::DEFAULT_DEPTH,
  parameter int WORD_WIDTH = dobf_pkg::DEFAULT_WORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dobf_pkg::ctrl_cmd_t              cmd,
  input  logic [dobf_pkg::CMD_W-1:0]       in_command,
  input  logic [dobf_pkg::PUSH_W-1:0]      in_push_word,
  input  logic                             cfg_wr_en,
  input  logic [dobf_pkg::LEVEL_W-1:0]     cfg_wr_data,
  output logic [dobf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dobf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > LEVEL_W) ? OCC_W : LEVEL_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  // Word store
  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_r;

  // Latched beat
  cmd_t                  cmd_r;
  logic [PUSH_W-1:0]     word_r;

  // FIFO state
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic [DROP_W-1:0]     drop_r, drop_nxt;
  logic [LEVEL_W-1:0]    max_level_r;

  // Result register
  logic                  res_ok_r, res_ok_nxt;
  logic [POP_W-1:0]      res_pop_r, res_pop_nxt;
  logic [DROP_W-1:0]     res_drop_r;
  logic                  res_full_r, res_full_nxt;
  logic [LEVEL_W-1:0]    res_level_r, res_level_nxt;

  // Width adaptation
  logic [WORD_WIDTH+PUSH_W-1:0] wr_ext;
  logic [WORD_WIDTH-1:0]        wr_word;
  logic [WORD_WIDTH+POP_W-1:0]  rd_ext;
  logic [OCC_W+LEVEL_W-1:0]     level_ext;
  logic [CMP_W-1:0]             limit, max_ext, occ_ext, occ_nxt_ext;
  logic                         at_limit;
  logic                         do_write;

  assign wr_ext    = {{WORD_WIDTH{1'b0}}, word_r};
  assign wr_word   = wr_ext[WORD_WIDTH-1:0];
  assign rd_ext    = {{POP_W{1'b0}}, rd_data_r};
  assign level_ext = {{LEVEL_W{1'b0}}, occ_nxt};

  // Clamp the configured limit to one through DEPTH
  assign max_ext = CMP_W'(max_level_r);
  always_comb begin
    if (max_level_r == '0) limit = CMP_W'(1);
    else if (max_ext > DEPTH_C) limit = DEPTH_C;
    else limit = max_ext;
  end

  assign occ_ext     = CMP_W'(occ_r);
  assign occ_nxt_ext = CMP_W'(occ_nxt);
  assign at_limit    = (occ_ext >= limit) && (occ_r != '0);

  // Apply the latched command
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    occ_nxt     = occ_r;
    drop_nxt    = drop_r;
    res_ok_nxt  = 1'b1;
    res_pop_nxt = '0;
    case (cmd_r)
      CMD_PUSH: begin
        tail_nxt = (tail_r == LAST_PTR) ? '0 : tail_r + PTR_W'(1);
        if (at_limit) begin
          // drop the oldest word, level stays
          head_nxt   = (head_r == LAST_PTR) ? '0 : head_r + PTR_W'(1);
          res_ok_nxt = 1'b0;
          if (drop_r != DROP_MAX) drop_nxt = drop_r + DROP_W'(1);
        end else begin
          occ_nxt = occ_r + OCC_W'(1);
        end
      end
      CMD_POP: begin
        if (occ_r != '0) begin
          head_nxt    = (head_r == LAST_PTR) ? '0 : head_r + PTR_W'(1);
          occ_nxt     = occ_r - OCC_W'(1);
          res_pop_nxt = rd_ext[POP_W-1:0];
        end else begin
          res_ok_nxt = 1'b0;
        end
      end
      CMD_CLEAR: begin
        head_nxt = '0;
        tail_nxt = '0;
        occ_nxt  = '0;
      end
      CMD_CLR_DROP: begin
        drop_nxt = '0;
      end
      default: begin
        res_ok_nxt = 1'b0;
      end
    endcase
    res_full_nxt  = (occ_nxt_ext >= limit);
    res_level_nxt = level_ext[LEVEL_W-1:0];
  end

  assign do_write = cmd.commit && (cmd_r == CMD_PUSH);

  // Store write and registered head read
  always_ff @(posedge clk) begin
    if (do_write) mem[tail_r] <= wr_word;
    if (cmd.capture) rd_data_r <= mem[head_r];
  end

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= cmd_t'(in_command);
      word_r <= in_push_word;
    end
  end

  // Advance FIFO state and the limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      drop_r      <= '0;
      max_level_r <= MAX_LEVEL_RESET;
    end else begin
      if (cmd.commit) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        occ_r  <= occ_nxt;
        drop_r <= drop_nxt;
      end
      if (cfg_wr_en) max_level_r <= cfg_wr_data;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_ok_r    <= res_ok_nxt;
      res_pop_r   <= res_pop_nxt;
      res_drop_r  <= drop_nxt;
      res_full_r  <= res_full_nxt;
      res_level_r <= res_level_nxt;
    end
  end

  assign out_tdata = {res_level_r, res_full_r, res_drop_r, res_pop_r, res_ok_r};

`ifndef SYNTHESIS
  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above store depth");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> (occ_r != '0))
    else $error("store empty after a push");

  a_drop_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(drop_r))
    else $error("drop counter moved without a command");
`endif

endmodule
